// File: design/lzg_pkg.sv
// shared types and constants for the gamma-coded lz77 depacker
`default_nettype none
package lzg_pkg;
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_COPY_RD
    } t_state;

    typedef enum logic [3:0] {
        PH_FIRST,
        PH_FLAG,
        PH_LIT,
        PH_LEN_BIT,
        PH_LEN_CONT,
        PH_OFF_BIT,
        PH_OFF_CONT,
        PH_OFF_BYTE,
        PH_COPY,
        PH_DONE,
        PH_ERR
    } t_phase;

    localparam logic       REQ_PUSH  = 1'b0;
    localparam logic [2:0] STAT_BYTE = 3'd0;
    localparam logic [2:0] STAT_NEED = 3'd1;
    localparam logic [2:0] STAT_DONE = 3'd2;
    localparam logic [2:0] STAT_ERR  = 3'd3;
    localparam logic [2:0] STAT_PUSH = 3'd4;

    localparam logic [4:0]  TAG_EMPTY = 5'd0;
    localparam logic [4:0]  TAG_HALF  = 5'd31;
    localparam logic [4:0]  TAG_FULL  = 5'd16;
    localparam logic [31:0] GAMMA_ONE = 32'd1;
    localparam logic [31:0] GAMMA_MAX = 32'hFFFF_FFFD;
endpackage
`default_nettype wire

// File: design/lzg_if.sv
// request and result channel interfaces
`default_nettype none
interface lzg_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] in_byte;
    modport source (output valid, output req_type, output in_byte, input ready);
    modport sink (input valid, input req_type, input in_byte, output ready);
endinterface

interface lzg_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;
    modport source (output valid, output out_byte, output status, output last, input ready);
    modport sink (input valid, input out_byte, input status, input last, output ready);
endinterface
`default_nettype wire

// File: design/lzg_ram.sv
// generic single-write single-read ram with registered read
`default_nettype none
module lzg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// File: design/lz77_gamma_depacker.sv
// lz77 depacker with gamma-coded matches and a history ram
// Usage:
//   i_req carries one beat per request: req_type 0 pushes in_byte into a
//   one-byte holding buffer, req_type 1 asks for the next output byte.
//   o_res returns exactly one beat per request: out_byte, status, last.
//   i_cfg_wr_en/i_cfg_wr_data set total_size while the block is idle.
// Timing:
//   a request is taken only in idle; the decoder then walks one token phase
//   per cycle (flag bits, gamma bits, offset byte) until it can answer.
//   a copied byte needs an extra state, ST_COPY_RD, for the history ram
//   read, which waits for a free output register; each flag or gamma bit
//   consumed adds a phase to the walk, and a request walks at most one tag
//   word plus the offset byte.
// Reset:
//   synchronous active low; decoder state, counters and the holding buffer
//   clear, history ram contents stay undefined (never read before written).
// Stall:
//   the result sits in the output register; if it is not taken the next
//   answer waits and its state update is held back until the register frees.
`default_nettype none
module lz77_gamma_depacker #(
    parameter int WINDOW_BYTES = 65536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    lzg_req_if.sink          i_req,
    lzg_res_if.source        o_res
);
    localparam int AW = $clog2(WINDOW_BYTES);
    localparam logic [AW:0]     WIN_EXT = (AW + 1)'(WINDOW_BYTES);
    localparam logic [AW-1:0]   WP_LAST = AW'(WINDOW_BYTES - 1);
    localparam logic [40:0]     WIN_41  = 41'(WINDOW_BYTES);

    lzg_pkg::t_state r_state, n_state;
    lzg_pkg::t_phase r_phase, n_phase;
    logic [AW-1:0] r_wp, n_wp;
    logic [31:0]   r_bytes_out, n_bytes_out;
    logic [15:0]   r_tag, n_tag;
    logic [4:0]    r_bits, n_bits;
    logic [31:0]   r_gamma, n_gamma;
    logic [31:0]   r_len, n_len;
    logic [AW:0]   r_off, n_off;
    logic [7:0]    r_hold, n_hold;
    logic          r_hold_v, n_hold_v;
    logic [31:0]   r_total;
    logic          r_req_type;
    logic [7:0]    r_req_byte;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic [2:0]    r_out_status;
    logic          r_out_last;

    logic          w_out_free, w_answer, w_copy_issue, w_commit, w_emit;
    logic [7:0]    w_a_byte, w_emit_byte;
    logic [2:0]    w_a_stat;
    logic          w_a_last;
    logic [31:0]   w_bo_inc;
    logic [40:0]   w_off;
    logic [AW:0]   w_wp_ext;
    logic [AW-1:0] w_rd_addr;
    logic [7:0]    w_ram_rdata;
    logic          w_ram_re;

    // next flag bit from the tag word
    logic          nb_need, nb_bit, nb_take;
    logic [15:0]   nb_tag, nb_tag_ld;
    logic [4:0]    nb_bits;

    always_comb begin
        nb_need   = 1'b0;
        nb_bit    = 1'b0;
        nb_take   = 1'b0;
        nb_tag    = r_tag;
        nb_bits   = r_bits;
        nb_tag_ld = {r_hold, r_tag[7:0]};
        if (r_bits == lzg_pkg::TAG_EMPTY) begin
            // low byte only, the high byte needs another push
            nb_need = 1'b1;
            if (r_hold_v) begin
                nb_take = 1'b1;
                nb_tag  = {8'd0, r_hold};
                nb_bits = lzg_pkg::TAG_HALF;
            end
        end else if (r_bits == lzg_pkg::TAG_HALF) begin
            if (r_hold_v) begin
                nb_take = 1'b1;
                nb_bit  = nb_tag_ld[15];
                nb_tag  = {nb_tag_ld[14:0], 1'b0};
                nb_bits = lzg_pkg::TAG_FULL - 5'd1;
            end else begin
                nb_need = 1'b1;
            end
        end else begin
            nb_bit  = r_tag[15];
            nb_tag  = {r_tag[14:0], 1'b0};
            nb_bits = r_bits - 5'd1;
        end
    end

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_bo_inc   = (r_bytes_out == 32'hFFFF_FFFF) ? r_bytes_out : r_bytes_out + 32'd1;
    assign w_off      = {1'b0, r_gamma - 32'd2, 8'd0} + {33'd0, r_hold} + 41'd1;
    assign w_wp_ext   = {1'b0, r_wp};
    assign w_rd_addr  = (w_wp_ext >= r_off) ? AW'(w_wp_ext - r_off)
                                            : AW'(w_wp_ext + WIN_EXT - r_off);

    always_comb begin
        n_phase      = r_phase;
        n_wp         = r_wp;
        n_bytes_out  = r_bytes_out;
        n_tag        = r_tag;
        n_bits       = r_bits;
        n_gamma      = r_gamma;
        n_len        = r_len;
        n_off        = r_off;
        n_hold       = r_hold;
        n_hold_v     = r_hold_v;
        w_answer     = 1'b0;
        w_copy_issue = 1'b0;
        w_emit       = 1'b0;
        w_emit_byte  = r_hold;
        w_a_byte     = 8'd0;
        w_a_stat     = lzg_pkg::STAT_NEED;
        w_a_last     = 1'b0;
        w_ram_re     = 1'b0;
        if (r_state == lzg_pkg::ST_COPY_RD) begin
            w_emit      = 1'b1;
            w_emit_byte = w_ram_rdata;
            n_len       = r_len - 32'd1;
            if (r_len == 32'd1) begin
                n_phase = lzg_pkg::PH_FLAG;
            end
        end else if (r_state == lzg_pkg::ST_RUN) begin
            if (r_req_type == lzg_pkg::REQ_PUSH) begin
                w_answer = 1'b1;
                w_a_stat = lzg_pkg::STAT_PUSH;
                w_a_byte = {7'd0, !r_hold_v};
                if (!r_hold_v) begin
                    n_hold   = r_req_byte;
                    n_hold_v = 1'b1;
                end
            end else begin
                unique case (r_phase)
                    lzg_pkg::PH_FIRST, lzg_pkg::PH_LIT: begin
                        if (r_phase == lzg_pkg::PH_FIRST && r_total == 32'd0) begin
                            n_phase = lzg_pkg::PH_DONE;
                        end else if (!r_hold_v) begin
                            w_answer = 1'b1;
                        end else begin
                            n_hold_v = 1'b0;
                            n_phase  = lzg_pkg::PH_FLAG;
                            w_emit   = 1'b1;
                        end
                    end
                    lzg_pkg::PH_FLAG: begin
                        if (r_bytes_out >= r_total) begin
                            n_phase = lzg_pkg::PH_DONE;
                        end else begin
                            n_tag  = nb_tag;
                            n_bits = nb_bits;
                            if (nb_take) n_hold_v = 1'b0;
                            if (nb_need) begin
                                w_answer = 1'b1;
                            end else begin
                                n_gamma = lzg_pkg::GAMMA_ONE;
                                n_phase = nb_bit ? lzg_pkg::PH_LEN_BIT : lzg_pkg::PH_LIT;
                            end
                        end
                    end
                    lzg_pkg::PH_LEN_BIT, lzg_pkg::PH_OFF_BIT: begin
                        n_tag  = nb_tag;
                        n_bits = nb_bits;
                        if (nb_take) n_hold_v = 1'b0;
                        if (nb_need) begin
                            w_answer = 1'b1;
                        end else if (r_gamma[31]) begin
                            n_phase = lzg_pkg::PH_ERR;
                        end else begin
                            n_gamma = {r_gamma[30:0], nb_bit};
                            n_phase = (r_phase == lzg_pkg::PH_LEN_BIT) ? lzg_pkg::PH_LEN_CONT
                                                                       : lzg_pkg::PH_OFF_CONT;
                        end
                    end
                    lzg_pkg::PH_LEN_CONT: begin
                        n_tag  = nb_tag;
                        n_bits = nb_bits;
                        if (nb_take) n_hold_v = 1'b0;
                        if (nb_need) begin
                            w_answer = 1'b1;
                        end else if (nb_bit) begin
                            n_phase = lzg_pkg::PH_LEN_BIT;
                        end else if (r_gamma > lzg_pkg::GAMMA_MAX) begin
                            n_phase = lzg_pkg::PH_ERR;
                        end else begin
                            n_len   = r_gamma + 32'd2;
                            n_gamma = lzg_pkg::GAMMA_ONE;
                            n_phase = lzg_pkg::PH_OFF_BIT;
                        end
                    end
                    lzg_pkg::PH_OFF_CONT: begin
                        n_tag  = nb_tag;
                        n_bits = nb_bits;
                        if (nb_take) n_hold_v = 1'b0;
                        if (nb_need) begin
                            w_answer = 1'b1;
                        end else begin
                            n_phase = nb_bit ? lzg_pkg::PH_OFF_BIT : lzg_pkg::PH_OFF_BYTE;
                        end
                    end
                    lzg_pkg::PH_OFF_BYTE: begin
                        if (!r_hold_v) begin
                            w_answer = 1'b1;
                        end else begin
                            n_hold_v = 1'b0;
                            n_gamma  = lzg_pkg::GAMMA_ONE;
                            if (w_off > {9'd0, r_bytes_out} || w_off > WIN_41) begin
                                n_phase = lzg_pkg::PH_ERR;
                            end else begin
                                n_off   = w_off[AW:0];
                                n_phase = lzg_pkg::PH_COPY;
                            end
                        end
                    end
                    lzg_pkg::PH_COPY: begin
                        w_ram_re     = 1'b1;
                        w_copy_issue = 1'b1;
                    end
                    lzg_pkg::PH_DONE: begin
                        w_answer = 1'b1;
                        w_a_stat = lzg_pkg::STAT_DONE;
                    end
                    default: begin
                        n_phase  = lzg_pkg::PH_ERR;
                        w_answer = 1'b1;
                        w_a_stat = lzg_pkg::STAT_ERR;
                    end
                endcase
            end
        end
        if (w_emit) begin
            w_answer    = 1'b1;
            w_a_stat    = lzg_pkg::STAT_BYTE;
            w_a_byte    = w_emit_byte;
            w_a_last    = (w_bo_inc == r_total);
            n_wp        = (r_wp == WP_LAST) ? '0 : r_wp + AW'(1);
            n_bytes_out = w_bo_inc;
        end
    end

    // an answer with a full output register holds the whole step back
    assign w_commit = !(w_answer && !w_out_free);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lzg_pkg::ST_IDLE: begin
                if (i_req.valid) n_state = lzg_pkg::ST_RUN;
            end
            lzg_pkg::ST_RUN: begin
                if (w_answer && w_out_free) n_state = lzg_pkg::ST_IDLE;
                else if (w_copy_issue)      n_state = lzg_pkg::ST_COPY_RD;
            end
            lzg_pkg::ST_COPY_RD: begin
                if (w_out_free) n_state = lzg_pkg::ST_IDLE;
            end
            default: n_state = lzg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lzg_pkg::ST_IDLE;
            r_phase     <= lzg_pkg::PH_FIRST;
            r_wp        <= '0;
            r_bytes_out <= '0;
            r_tag       <= '0;
            r_bits      <= lzg_pkg::TAG_EMPTY;
            r_gamma     <= lzg_pkg::GAMMA_ONE;
            r_len       <= '0;
            r_off       <= '0;
            r_hold      <= '0;
            r_hold_v    <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_phase     <= n_phase;
                r_wp        <= n_wp;
                r_bytes_out <= n_bytes_out;
                r_tag       <= n_tag;
                r_bits      <= n_bits;
                r_gamma     <= n_gamma;
                r_len       <= n_len;
                r_off       <= n_off;
                r_hold      <= n_hold;
                r_hold_v    <= n_hold_v;
            end
            if (i_cfg_wr_en) r_total <= i_cfg_wr_data;
            if (w_answer && w_out_free) r_out_valid <= 1'b1;
            else if (o_res.ready)       r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lzg_pkg::ST_IDLE) begin
            r_req_type <= i_req.req_type;
            r_req_byte <= i_req.in_byte;
        end
        if (w_answer && w_out_free) begin
            r_out_byte   <= w_a_byte;
            r_out_status <= w_a_stat;
            r_out_last   <= w_a_last;
        end
    end

    lzg_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_BYTES)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_emit && w_out_free),
        .i_waddr (r_wp),
        .i_wdata (w_emit_byte),
        .i_re    (w_ram_re),
        .i_raddr (w_rd_addr),
        .o_rdata (w_ram_rdata)
    );

    assign i_req.ready    = (r_state == lzg_pkg::ST_IDLE);
    assign o_res.valid    = r_out_valid;
    assign o_res.out_byte = r_out_byte;
    assign o_res.status   = r_out_status;
    assign o_res.last     = r_out_last;
endmodule
`default_nettype wire

// File: design/lzg_chk.sv
// port-level checks for the depacker, bound to the top level
`default_nettype none
module lzg_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_req_valid,
    input wire logic       i_req_ready,
    input wire logic       i_res_valid,
    input wire logic       i_res_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic [2:0] i_status,
    input wire logic       i_last
);
    a_last_only_on_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_last |-> i_status == lzg_pkg::STAT_BYTE)
        else $error("last set on a non-byte result");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_status == lzg_pkg::STAT_NEED || i_status == lzg_pkg::STAT_DONE
                        || i_status == lzg_pkg::STAT_ERR) |-> i_out_byte == 8'd0)
        else $error("out_byte not zero on a status beat");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while one is in flight");

    a_res_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_status))
        else $error("stalled result dropped or changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");
endmodule

bind lz77_gamma_depacker lzg_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_out_byte  (o_res.out_byte),
    .i_status    (o_res.status),
    .i_last      (o_res.last)
);
`default_nettype wire

// File: tb/tb_lz77_gamma_depacker.sv
// testbench for the gamma-coded lz77 depacker: encoded random streams, predicted answers
`timescale 1ns / 1ps
`default_nettype none
module tb_lz77_gamma_depacker;
    import lzg_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_ITEMS = 1400;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       last;
    } t_answer;

    // tracks the decoder state and the answers it owes
    class depack_tracker;
        logic [7:0]  hist [0:65535];
        logic [15:0] wr_ptr;
        logic [31:0] produced;
        logic [31:0] tag;
        logic [4:0]  tag_left;
        logic [31:0] gam;
        logic [31:0] copy_left;
        logic [31:0] copy_dist;
        t_phase      ph;
        logic [7:0]  hold;
        bit          hold_ok;
        logic [31:0] total;
        t_answer     due[$];
        int          fails;

        function new();
            wr_ptr = '0;
            produced = '0;
            tag = '0;
            tag_left = TAG_EMPTY;
            gam = GAMMA_ONE;
            copy_left = '0;
            copy_dist = '0;
            ph = PH_FIRST;
            hold = '0;
            hold_ok = 0;
            total = '0;
            fails = 0;
        endfunction

        // -1 means the tag word is not loaded yet
        function int take_bit();
            int b;
            if (tag_left == TAG_EMPTY) begin
                if (!hold_ok) return -1;
                tag = {24'd0, hold};
                hold_ok = 0;
                tag_left = TAG_HALF;
            end
            if (tag_left == TAG_HALF) begin
                if (!hold_ok) return -1;
                tag = {16'd0, hold, tag[7:0]};
                hold_ok = 0;
                tag_left = TAG_FULL;
            end
            b = tag[15];
            tag = {16'd0, tag[14:0], 1'b0};
            tag_left = tag_left - 5'd1;
            return b;
        endfunction

        function t_answer put_byte(logic [7:0] v);
            t_answer a;
            hist[wr_ptr] = v;
            wr_ptr = wr_ptr + 16'd1;
            if (produced != 32'hFFFF_FFFF) produced = produced + 32'd1;
            a.out_byte = v;
            a.status = STAT_BYTE;
            a.last = (produced == total);
            return a;
        endfunction

        function void note_request(logic rt, logic [7:0] b);
            t_answer a;
            bit done;
            int bt;
            logic [63:0] back_off;
            a = '{out_byte: 8'd0, status: STAT_NEED, last: 1'b0};
            if (rt == REQ_PUSH) begin
                a.status = STAT_PUSH;
                if (!hold_ok) begin
                    hold = b;
                    hold_ok = 1;
                    a.out_byte = 8'd1;
                end
                due.push_back(a);
                return;
            end
            done = 0;
            while (!done) begin
                case (ph)
                    PH_FIRST: begin
                        if (total == 0) ph = PH_DONE;
                        else if (!hold_ok) done = 1;
                        else begin
                            hold_ok = 0;
                            ph = PH_FLAG;
                            a = put_byte(hold);
                            done = 1;
                        end
                    end
                    PH_FLAG: begin
                        if (produced >= total) ph = PH_DONE;
                        else begin
                            bt = take_bit();
                            if (bt < 0) done = 1;
                            else begin
                                gam = GAMMA_ONE;
                                ph = bt ? PH_LEN_BIT : PH_LIT;
                            end
                        end
                    end
                    PH_LIT: begin
                        if (hold_ok) begin
                            hold_ok = 0;
                            ph = PH_FLAG;
                            a = put_byte(hold);
                        end
                        done = 1;
                    end
                    PH_LEN_BIT, PH_OFF_BIT: begin
                        bt = take_bit();
                        if (bt < 0) done = 1;
                        else if (gam[31]) ph = PH_ERR;
                        else begin
                            gam = {gam[30:0], bt[0]};
                            ph = (ph == PH_LEN_BIT) ? PH_LEN_CONT : PH_OFF_CONT;
                        end
                    end
                    PH_LEN_CONT: begin
                        bt = take_bit();
                        if (bt < 0) done = 1;
                        else if (bt) ph = PH_LEN_BIT;
                        else if (gam > GAMMA_MAX) ph = PH_ERR;
                        else begin
                            copy_left = gam + 32'd2;
                            gam = GAMMA_ONE;
                            ph = PH_OFF_BIT;
                        end
                    end
                    PH_OFF_CONT: begin
                        bt = take_bit();
                        if (bt < 0) done = 1;
                        else ph = bt ? PH_OFF_BIT : PH_OFF_BYTE;
                    end
                    PH_OFF_BYTE: begin
                        if (!hold_ok) done = 1;
                        else begin
                            hold_ok = 0;
                            back_off = ({32'd0, gam - 32'd2} << 8) + {56'd0, hold} + 64'd1;
                            gam = GAMMA_ONE;
                            if (back_off > {32'd0, produced} || back_off > 64'd65536) ph = PH_ERR;
                            else begin
                                copy_dist = back_off[31:0];
                                ph = PH_COPY;
                            end
                        end
                    end
                    PH_COPY: begin
                        copy_left = copy_left - 32'd1;
                        if (copy_left == 0) ph = PH_FLAG;
                        a = put_byte(hist[wr_ptr - copy_dist[15:0]]);
                        done = 1;
                    end
                    PH_DONE: begin
                        a.status = STAT_DONE;
                        done = 1;
                    end
                    default: begin
                        ph = PH_ERR;
                        a.status = STAT_ERR;
                        done = 1;
                    end
                endcase
            end
            due.push_back(a);
        endfunction

        function void check_answer(t_answer got);
            t_answer want;
            if (due.size() == 0) begin
                $display("%0t: unexpected beat byte=%h status=%0d last=%b", $time,
                         got.out_byte, got.status, got.last);
                fails++;
                return;
            end
            want = due.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got.out_byte);
                fails++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                fails++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                fails++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [31:0] i_cfg_wr_data;
    lzg_req_if   req_ch();
    lzg_res_if   res_ch();

    lz77_gamma_depacker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_ch),
        .o_res         (res_ch)
    );

    depack_tracker trk = new();
    bit            idling = 1;
    int            sent = 0;
    int            cycles = 0;
    int            stall_left = 0;

    // stream encoder: tag words are held back with their group until all 16 bits are set
    logic [7:0]  feed[$];
    logic [7:0]  grp[$];
    logic [15:0] tag_val;
    int          tag_bits = 16;
    int          enc_out = 0;
    int          bad_end = 0;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (idling && stall_left == 0 && $urandom_range(0, 9) == 0)
            stall_left <= $urandom_range(1, 18);
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        res_ch.ready <= !(idling && stall_left > 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            trk.check_answer('{out_byte: res_ch.out_byte, status: res_ch.status,
                               last: res_ch.last});
    end

    function void put_bit(bit b);
        if (tag_bits == 16) begin
            while (grp.size() != 0) feed.push_back(grp.pop_front());
            grp.push_back(8'd0);
            grp.push_back(8'd0);
            tag_val = '0;
            tag_bits = 0;
        end
        tag_val[15 - tag_bits] = b;
        tag_bits++;
        grp[0] = tag_val[7:0];
        grp[1] = tag_val[15:8];
    endfunction

    function void put_gamma(logic [31:0] v);
        int top;
        top = 0;
        for (int i = 0; i < 32; i++) if (v[i]) top = i;
        for (int i = top - 1; i >= 0; i--) begin
            put_bit(v[i]);
            put_bit(i > 0);
        end
    endfunction

    function void add_token();
        int span;
        int len;
        int reach;
        if (bad_end == 1) begin
            // match reaching before the first byte written
            put_bit(1);
            put_gamma(2);
            span = enc_out + $urandom_range(1, 300);
            put_gamma(((span - 1) >> 8) + 2);
            grp.push_back(8'((span - 1) & 255));
            bad_end = 3;
        end else if (bad_end == 2) begin
            // length gamma that never terminates
            put_bit(1);
            repeat (34) begin
                put_bit(1);
                put_bit(1);
            end
            bad_end = 3;
        end else if ($urandom_range(0, 99) < 55) begin
            put_bit(0);
            grp.push_back(8'($urandom_range(0, 255)));
            enc_out++;
        end else begin
            reach = (enc_out < 65536) ? enc_out : 65536;
            if ($urandom_range(0, 3) == 0) span = $urandom_range(1, reach);
            else span = $urandom_range(1, (reach < 40) ? reach : 40);
            len = ($urandom_range(0, 24) == 0) ? $urandom_range(4, 300) : $urandom_range(4, 12);
            put_bit(1);
            put_gamma(len - 2);
            put_gamma(((span - 1) >> 8) + 2);
            grp.push_back(8'((span - 1) & 255));
            enc_out += len;
        end
    endfunction

    task automatic send(logic rt, logic [7:0] b);
        if (idling && $urandom_range(0, 7) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= rt;
        req_ch.in_byte <= b;
        do @(posedge i_clk); while (!req_ch.ready);
        trk.note_request(rt, b);
        sent++;
    endtask

    task automatic push_stream();
        while (feed.size() == 0) add_token();
        send(REQ_PUSH, feed.pop_front());
    endtask

    task automatic one_item();
        if (!trk.hold_ok && $urandom_range(0, 9) < 8) push_stream();
        else if (trk.hold_ok && $urandom_range(0, 19) == 0)
            send(REQ_PUSH, 8'($urandom_range(0, 255)));
        else send(!REQ_PUSH, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (trk.due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_total(logic [31:0] v);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        trk.total = v;
    endtask

    initial begin
        int ending;
        i_clk = 0;
        i_rst_n = 0;
        i_cfg_wr_en = 0;
        i_cfg_wr_data = '0;
        req_ch.valid = 0;
        req_ch.req_type = 0;
        req_ch.in_byte = '0;
        res_ch.ready = 1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_total(32'hFFFF_FFFF);
        // starved request, first literal, rejected pushes with extreme bytes
        feed.push_back(8'hA5);
        enc_out = 1;
        send(!REQ_PUSH, 8'h00);
        push_stream();
        send(REQ_PUSH, 8'h00);
        send(REQ_PUSH, 8'hFF);
        send(!REQ_PUSH, 8'hFF);
        send(!REQ_PUSH, 8'h00);
        repeat (14) one_item();

        while (sent < RANDOM_ITEMS) begin
            one_item();
            if (sent == RANDOM_ITEMS / 2)
                write_total(32'h8000_0000 | 32'($urandom_range(0, 32'h7FFF_FFFF)));
        end

        // final part: no idling, then done or one of the error cases
        idling = 0;
        ending = $urandom_range(0, 2);
        if (ending == 0) write_total(trk.produced + 32'($urandom_range(1, 24)));
        else bad_end = ending;
        while (trk.ph != PH_DONE && trk.ph != PH_ERR) one_item();
        repeat (4) send(!REQ_PUSH, 8'h00);
        push_stream();
        write_total(32'd0);
        repeat (3) send(!REQ_PUSH, 8'h00);
        drain();
        repeat (20) @(posedge i_clk);

        if (trk.fails == 0 && trk.due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
